### rtl/sidtoa_pkg.sv
package sidtoa_pkg;

   localparam int VALUE_BITS_DEF = 32;

   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_MINUS = 7'd45;

   // Datapath commands from the sequencer to the shift-add-3 unit.
   typedef struct packed {
      logic load;    // take a new magnitude, clear the BCD register
      logic dabble;  // one shift-add-3 step, one binary bit in
      logic dshift;  // drop the top BCD digit, shift one digit up
   } sidtoa_ctrl_type;

endpackage

### rtl/sidtoa_dabble.sv
module sidtoa_dabble
   import sidtoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int NDIG       = (VALUE_BITS - 1) * 30103 / 100000 + 1
) (
   input  logic                  clock,
   input  sidtoa_ctrl_type       ctrl,
   input  logic [VALUE_BITS-1:0] load_value,
   input  logic                  load_neg,
   output logic [3:0]            top_digit
);

   localparam int BCD_W = NDIG * 4;

   logic [VALUE_BITS-1:0] mag_ff;
   logic [VALUE_BITS-1:0] mag_in;
   logic [BCD_W-1:0]      bcd_ff;
   logic [BCD_W-1:0]      bcd_in;
   logic [BCD_W-1:0]      bcd_adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         mag_in = load_neg ? (~load_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : load_value;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
      end else if (ctrl.dshift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Input channel (req_): one beat carries a signed VALUE_BITS-bit integer in
// req_value. Result channel (rsp_): one beat per character, most significant
// first: '-' for a negative value, then the digits with no leading zeros;
// zero gives a single '0'. rsp_last marks the final character of a value.
// The most negative value converts exactly (magnitude held unsigned).
// Timing: the magnitude is converted by a shift-add-3 loop that takes one
// binary bit per cycle. Leading zero digits are then dropped one per cycle,
// and characters go out one per cycle while the receiver does not stall.
// req_stall is high from acceptance until the final character has been
// loaded into the output register; the next value may be taken while that
// character still waits. A stall on rsp_ holds the output register and
// freezes emission. Reset (synchronous, active high) drops any value in
// flight and clears rsp_valid.
module signed_int_to_decimal_ascii
   import sidtoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [6:0]                   rsp_character,
   output logic                         rsp_last
);

   // decimal digits of 2^(VALUE_BITS-1), the largest magnitude
   localparam int NDIG    = (VALUE_BITS - 1) * 30103 / 100000 + 1;
   localparam int BCNT_W  = $clog2(VALUE_BITS + 1);
   localparam int DCNT_W  = $clog2(NDIG + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [BCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic              neg_ff, neg_in;
   logic              sign_pend_ff, sign_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [6:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   sidtoa_ctrl_type   ctrl;
   logic [3:0]        top_digit;
   logic              req_take;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   // output register can take a beat this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sidtoa_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NDIG       (NDIG)
   ) u_dabble (
      .clock      (clock),
      .ctrl       (ctrl),
      .load_value ($unsigned(req_value)),
      .load_neg   (req_value[VALUE_BITS-1]),
      .top_digit  (top_digit)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ctrl.load    = 1'b1;
               neg_in       = req_value[VALUE_BITS-1];
               sign_pend_in = req_value[VALUE_BITS-1];
               bit_cnt_in   = BCNT_W'(VALUE_BITS);
               state_in     = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl.dabble = 1'b1;
            bit_cnt_in  = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BCNT_W'(1)) begin
               dig_cnt_in = DCNT_W'(NDIG);
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, always keep the units digit
            if (top_digit == 4'd0 && dig_cnt_ff != DCNT_W'(1)) begin
               ctrl.dshift = 1'b1;
               dig_cnt_in  = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_pend_ff) begin
                  rsp_char_in  = CHAR_MINUS;
                  rsp_last_in  = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  rsp_char_in = CHAR_ZERO + {3'b000, top_digit};
                  rsp_last_in = (dig_cnt_ff == DCNT_W'(1));
                  ctrl.dshift = 1'b1;
                  dig_cnt_in  = dig_cnt_ff - 1'b1;
                  if (dig_cnt_ff == DCNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_pend_ff <= sign_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // BCD digits stay legal through conversion and emission
   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (top_digit <= 4'd9))
      else $error("top BCD digit out of range");

   // an accepted beat always starts a conversion
   a_take_conv: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CONV))
      else $error("accepted value did not start conversion");

   // digit count never runs out before the final character
   a_dig_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> (dig_cnt_ff != '0))
      else $error("digit count exhausted while emitting");

   // minus only for a negative value
   a_sign: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && sign_pend_ff) |-> neg_ff)
      else $error("sign pending on a non-negative value");

endmodule
